[hdl/bdqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with search - shared definitions
// Payload structs, action codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int ACTION_W       = 3;
    localparam int ITEM_W         = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ITEM_W-1:0]   item_value;
    } t_item;

    typedef struct packed {
        logic                ok;
        logic [ITEM_W-1:0]   removed_value;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_pop;
        logic rd_scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                empty;
        logic                match;
        logic                scan_last;
    } t_status;

endpackage

[hdl/bounded_deque_with_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with search - top level
// Up to DEPTH elements in front-to-back order with push/pop at both ends,
// clear, and a front-to-back membership search. One result per transaction,
// presented for one cycle on o_valid; the receiver cannot stall it.
// Timing: start is taken when busy is low. Push, clear, unused codes, a pop
// or search on an empty store: decode in EXEC, then the registered result;
// the next transaction is accepted in the result cycle. A pop reads the
// element memory once (EXEC, RDWAIT, result). A search reads and compares
// one stored element per cycle and stops at the first match or after the
// last stored element.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core
    import bdqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    t_cmd    w_cmd;
    t_status w_status;

    bdqs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    bdqs_dpath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

[hdl/bdqs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with search - controller
// Sequences one transaction at a time: decode, optional memory read for a
// pop, element-by-element scan for a search, then result.
// ----------------------------------------------------------------------------
module bdqs_ctrl
    import bdqs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_status.action)
                    ACT_POP_FRONT, ACT_POP_BACK: begin
                        n_state = i_status.empty ? ST_IDLE : ST_RDWAIT;
                    end
                    ACT_SEARCH: begin
                        n_state = i_status.empty ? ST_IDLE : ST_SCAN;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RDWAIT: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_status.match || i_status.scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
            end
            ST_EXEC: begin
                case (i_status.action)
                    ACT_POP_FRONT, ACT_POP_BACK: begin
                        o_cmd.rd_pop = !i_status.empty;
                        o_cmd.finish = i_status.empty;
                    end
                    ACT_SEARCH: begin
                        o_cmd.rd_scan = !i_status.empty;
                        o_cmd.finish  = i_status.empty;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            ST_RDWAIT: begin
                o_cmd.finish = 1'b1;
            end
            ST_SCAN: begin
                if (i_status.match || i_status.scan_last) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_pop_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_pop |=> o_cmd.finish)
        else $error("pop read not completed in the following cycle");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_busy)
        else $error("controller did not return to idle after a result");

endmodule

[hdl/bdqs_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with search - datapath
// Circular element store, head and count registers, scan cursor, key
// compare and the registered result.
// ----------------------------------------------------------------------------
module bdqs_dpath
    import bdqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output logic    o_valid,
    output t_result o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (ELEM_WIDTH < ITEM_W) ? ELEM_WIDTH : ITEM_W;

    logic [SW-1:0]       r_mem [DEPTH];
    logic [SW-1:0]       r_rdata;
    logic [SW-1:0]       r_key;
    logic [ACTION_W-1:0] r_action;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       n_head;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_cursor;
    logic                r_valid;
    t_result             r_result;
    t_result             n_result;

    logic          w_full;
    logic          w_empty;
    logic          w_match;
    logic          w_wr_en;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_head_dec;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [PW-1:0] off);
        logic [PW-1:0] s;
        s = PW'(base) + off;
        if (s >= PW'(DEPTH)) begin
            s = s - PW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_match    = (r_rdata == r_key);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;

    assign o_status.action    = r_action;
    assign o_status.empty     = w_empty;
    assign o_status.match     = w_match;
    assign o_status.scan_last = (r_cursor == r_count);

    always_comb begin
        if (i_cmd.rd_scan) begin
            w_raddr = slot(r_head, PW'(r_cursor));
        end else if (r_action == ACT_POP_BACK) begin
            w_raddr = slot(r_head, PW'(r_count - 1'b1));
        end else begin
            w_raddr = r_head;
        end
    end

    always_comb begin
        n_head          = r_head;
        n_count         = r_count;
        w_wr_en         = 1'b0;
        w_waddr         = slot(r_head, PW'(r_count));
        n_result        = '0;
        case (r_action)
            ACT_PUSH_FRONT: begin
                w_waddr = w_head_dec;
                if (!w_full) begin
                    w_wr_en     = 1'b1;
                    n_head      = w_head_dec;
                    n_count     = r_count + 1'b1;
                    n_result.ok = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (!w_full) begin
                    w_wr_en     = 1'b1;
                    n_count     = r_count + 1'b1;
                    n_result.ok = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (!w_empty) begin
                    n_head                 = slot(r_head, PW'(1));
                    n_count                = r_count - 1'b1;
                    n_result.ok            = 1'b1;
                    n_result.removed_value = ITEM_W'(r_rdata);
                end
            end
            ACT_POP_BACK: begin
                if (!w_empty) begin
                    n_count                = r_count - 1'b1;
                    n_result.ok            = 1'b1;
                    n_result.removed_value = ITEM_W'(r_rdata);
                end
            end
            ACT_SEARCH: begin
                n_result.ok    = 1'b1;
                n_result.found = !w_empty && w_match;
            end
            ACT_CLEAR: begin
                n_head      = '0;
                n_count     = '0;
                n_result.ok = 1'b1;
            end
            default: begin
                n_result.ok = 1'b0;
            end
        endcase
        n_result.count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_wr_en) begin
            r_mem[w_waddr] <= r_key;
        end
        if (i_cmd.rd_pop || i_cmd.rd_scan) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_key    <= i_item.item_value[SW-1:0];
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_cursor <= '0;
            end else if (i_cmd.rd_scan) begin
                r_cursor <= r_cursor + 1'b1;
            end
            if (i_cmd.finish) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !w_full
         && (r_action == ACT_PUSH_FRONT || r_action == ACT_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not advance the count");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_action == ACT_CLEAR) |=> (r_count == '0 && r_head == '0))
        else $error("clear left elements in the store");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with search - block testbench
// Drives push, pop, search and clear transactions through the start/busy
// handshake and keeps its own copy of the circular store. Each strobed result
// is compared field by field with the oldest predicted one. Directed checks
// cover the empty and full store and the single element. Random traffic then
// alternates fill and drain phases, with search keys mostly taken from the
// stored elements.
// ----------------------------------------------------------------------------
module tb_top;
    import bdqs_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 750;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    logic [ITEM_W-1:0] deque_store [DEPTH];
    int                deque_head;
    int                deque_count;
    t_result           pending_results[$];
    int                error_count = 0;
    int                stall_cycles = 0;
    bit                idle_enable = 1'b1;

    bounded_deque_with_search_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_result predict_deque_op(input t_item it);
        t_result r;
        int      idx;
        r = '0;
        case (it.action)
            ACT_PUSH_FRONT: begin
                if (deque_count < DEPTH) begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_store[deque_head] = it.item_value;
                    deque_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (deque_count < DEPTH) begin
                    deque_store[(deque_head + deque_count) % DEPTH] = it.item_value;
                    deque_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (deque_count > 0) begin
                    r.removed_value = deque_store[deque_head];
                    deque_head = (deque_head + 1) % DEPTH;
                    deque_count--;
                    r.ok = 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (deque_count > 0) begin
                    r.removed_value = deque_store[(deque_head + deque_count - 1) % DEPTH];
                    deque_count--;
                    r.ok = 1'b1;
                end
            end
            ACT_SEARCH: begin
                r.ok = 1'b1;
                for (idx = 0; idx < deque_count && !r.found; idx++) begin
                    if (deque_store[(deque_head + idx) % DEPTH] == it.item_value) begin
                        r.found = 1'b1;
                    end
                end
            end
            ACT_CLEAR: begin
                deque_head  = 0;
                deque_count = 0;
                r.ok        = 1'b1;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(deque_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [ITEM_W-1:0] got,
                                   input logic [ITEM_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input t_item it);
        int      gap;
        t_result want;
        gap = 0;
        if (idle_enable && $urandom_range(0, 99) < 31) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        want = predict_deque_op(it);
        pending_results.push_back(want);
    endtask

    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [ITEM_W-1:0] val);
        t_item it;
        it.action     = act;
        it.item_value = val;
        send_item(it);
    endtask

    function automatic logic [ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ITEM_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ITEM_W-1:0] pick_search_key();
        if (deque_count > 0 && $urandom_range(0, 99) < 60) begin
            return deque_store[(deque_head + $urandom_range(0, deque_count - 1)) % DEPTH];
        end
        return pick_value();
    endfunction

    task automatic test_empty_store();
        send_op(ACT_POP_FRONT, 32'h0);
        send_op(ACT_POP_BACK, 32'h0);
        send_op(ACT_SEARCH, 32'h0);
        send_op(3'd7, 32'hFFFF_FFFF);
    endtask

    task automatic test_single_element();
        send_op(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(ACT_POP_BACK, 32'h0);
    endtask

    task automatic test_fill_to_capacity();
        logic [ITEM_W-1:0] val;
        logic [ITEM_W-1:0] last_back;
        val       = '0;
        last_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            val = (32'h1 << (2 * i)) ^ {16'(i), 16'hA5C3};
            if (i % 2 == 0) begin
                send_op(ACT_PUSH_FRONT, val);
            end else begin
                send_op(ACT_PUSH_BACK, val);
                last_back = val;
            end
        end
        send_op(ACT_PUSH_BACK, 32'h1234_5678);
        send_op(ACT_SEARCH, last_back);
        send_op(ACT_CLEAR, 32'h0);
    endtask

    task automatic test_random_traffic();
        t_item it;
        int    sent;
        int    r;
        bit    fill_phase;
        sent       = 0;
        fill_phase = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 50 == 0) fill_phase = ~fill_phase;
            idle_enable = !(sent >= 300 && sent < 450);
            r = $urandom_range(0, 99);
            it.item_value = pick_value();
            if (fill_phase) begin
                if      (r < 30) it.action = ACT_PUSH_FRONT;
                else if (r < 60) it.action = ACT_PUSH_BACK;
                else if (r < 70) it.action = ACT_POP_FRONT;
                else if (r < 80) it.action = ACT_POP_BACK;
                else if (r < 95) it.action = ACT_SEARCH;
                else if (r < 97) it.action = ACT_CLEAR;
                else             it.action = ACTION_W'($urandom_range(6, 7));
            end else begin
                if      (r < 12) it.action = ACT_PUSH_FRONT;
                else if (r < 24) it.action = ACT_PUSH_BACK;
                else if (r < 47) it.action = ACT_POP_FRONT;
                else if (r < 70) it.action = ACT_POP_BACK;
                else if (r < 95) it.action = ACT_SEARCH;
                else if (r < 97) it.action = ACT_CLEAR;
                else             it.action = ACTION_W'($urandom_range(6, 7));
            end
            if (it.action == ACT_SEARCH) it.item_value = pick_search_key();
            send_item(it);
            if (it.action <= ACT_CLEAR) sent++;
        end
        idle_enable = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", ITEM_W'(o_result), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.ok !== want.ok)
                    report_mismatch("ok", ITEM_W'(o_result.ok), ITEM_W'(want.ok));
                if (o_result.removed_value !== want.removed_value)
                    report_mismatch("removed_value", o_result.removed_value,
                                    want.removed_value);
                if (o_result.found !== want.found)
                    report_mismatch("found", ITEM_W'(o_result.found), ITEM_W'(want.found));
                if (o_result.count !== want.count)
                    report_mismatch("count", ITEM_W'(o_result.count), ITEM_W'(want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        deque_head  = 0;
        deque_count = 0;
        for (int i = 0; i < DEPTH; i++) deque_store[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_single_element();
        test_fill_to_capacity();
        test_random_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
